// ----- rtl/bdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types and constants of the button debounce / click / long-press block
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

  // event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_PRESSED  = 3'd1;
  localparam logic [2:0] EV_RELEASED = 3'd2;
  localparam logic [2:0] EV_LONG     = 3'd3;
  localparam logic [2:0] EV_CLICK    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_SETTLING   = 2'd0;
  localparam logic [1:0] REG_CLICK_GAP  = 2'd1;
  localparam logic [1:0] REG_LONG_PRESS = 2'd2;
  localparam logic [1:0] REG_REPEAT     = 2'd3;

  // reset values of the registers, in milliseconds
  localparam logic [15:0] SETTLING_RST   = 16'd10;
  localparam logic [15:0] CLICK_GAP_RST  = 16'd200;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [15:0] REPEAT_RST     = 16'd100;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [15:0] settling_ms;
    logic [15:0] click_gap_ms;
    logic [15:0] long_press_ms;
    logic [15:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [7:0] event_count;
    logic       button_down;
  } res_t;

  // saturating increment of an 8 bit count
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bdc_poll_if.sv -----
// ----------------------------------------------------------------------------
// bdc_poll_if
// Poll channel: raw pin level and millisecond timestamp
// ----------------------------------------------------------------------------
`default_nettype none

interface bdc_poll_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

`default_nettype wire

// ----- rtl/bdc_event_if.sv -----
// ----------------------------------------------------------------------------
// bdc_event_if
// Event channel: event code, count and debounced button state
// ----------------------------------------------------------------------------
`default_nettype none

interface bdc_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic [7:0] event_count;
  logic       button_down;

  modport source (output valid, output event_code, output event_count,
                  output button_down, input ready);
  modport sink   (input valid, input event_code, input event_count,
                  input button_down, output ready);
endinterface

`default_nettype wire

// ----- rtl/bdc_cfg.sv -----
// ----------------------------------------------------------------------------
// bdc_cfg
// Timing configuration registers with a plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_cfg
  import bdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settling_ms   <= SETTLING_RST;
      cfg.click_gap_ms  <= CLICK_GAP_RST;
      cfg.long_press_ms <= LONG_PRESS_RST;
      cfg.repeat_ms     <= REPEAT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETTLING:   cfg.settling_ms   <= cfg_data;
        REG_CLICK_GAP:  cfg.click_gap_ms  <= cfg_data;
        REG_LONG_PRESS: cfg.long_press_ms <= cfg_data;
        REG_REPEAT:     cfg.repeat_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bdc_core.sv -----
// ----------------------------------------------------------------------------
// bdc_core
// Debounce state and event decision for one poll per cycle while step is high
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_core
  import bdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        step,
  input  wire logic        pin_level,
  input  wire logic [31:0] now_ms,
  output res_t             res
);

  logic        debounced_down, debounced_down_next;
  logic        change_pending, change_pending_next;
  logic [31:0] pending_since, pending_since_next;
  logic [31:0] press_time, press_time_next;
  logic [31:0] release_time, release_time_next;
  logic [31:0] repeat_time, repeat_time_next;
  logic [7:0]  long_ticks, long_ticks_next;
  logic [7:0]  click_count, click_count_next;

  logic        down_now;
  logic [31:0] pend_age, held_len, long_age, rep_age, idle_age;
  logic [2:0]  code;
  logic [7:0]  count;

  assign down_now = ~pin_level;

  // next state and event of the current poll
  always_comb begin
    debounced_down_next = debounced_down;
    change_pending_next = change_pending;
    pending_since_next  = pending_since;
    press_time_next     = press_time;
    release_time_next   = release_time;
    repeat_time_next    = repeat_time;
    long_ticks_next     = long_ticks;
    click_count_next    = click_count;
    code                = EV_NONE;
    count               = 8'd0;

    pend_age = now_ms - pending_since;
    held_len = now_ms - press_time;

    // debounce: accept a change once it has settled
    if (change_pending) begin
      if (pend_age >= {16'd0, cfg.settling_ms}) begin
        if (down_now != debounced_down) begin
          if (down_now) begin
            press_time_next = now_ms;
            code            = EV_PRESSED;
          end else begin
            release_time_next = now_ms;
            code              = EV_RELEASED;
            long_ticks_next   = 8'd0;
            if (held_len < {16'd0, cfg.long_press_ms}) begin
              click_count_next = sat_inc(click_count);
            end else begin
              click_count_next = 8'd0;
            end
          end
        end
        debounced_down_next = down_now;
        change_pending_next = 1'b0;
      end
    end else if (down_now != debounced_down) begin
      pending_since_next  = now_ms;
      change_pending_next = 1'b1;
    end

    long_age = now_ms - press_time_next;
    rep_age  = now_ms - repeat_time;

    // long press, first firing and repeats
    if (debounced_down_next) begin
      if (long_ticks_next == 8'd0) begin
        if (long_age > {16'd0, cfg.long_press_ms}) begin
          long_ticks_next  = 8'd1;
          repeat_time_next = now_ms;
          code             = EV_LONG;
          count            = 8'd1;
        end
      end else if (rep_age > {16'd0, cfg.repeat_ms}) begin
        repeat_time_next = now_ms;
        long_ticks_next  = sat_inc(long_ticks_next);
        code             = EV_LONG;
        count            = long_ticks_next;
      end
    end

    idle_age = now_ms - release_time_next;

    // click sequence ends after the gap
    if (click_count_next != 8'd0 && !debounced_down_next &&
        idle_age > {16'd0, cfg.click_gap_ms}) begin
      code             = EV_CLICK;
      count            = click_count_next;
      click_count_next = 8'd0;
    end

    res.event_code  = code;
    res.event_count = count;
    res.button_down = debounced_down_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounced_down <= 1'b0;
      change_pending <= 1'b0;
      pending_since  <= 32'd0;
      press_time     <= 32'd0;
      release_time   <= 32'd0;
      repeat_time    <= 32'd0;
      long_ticks     <= 8'd0;
      click_count    <= 8'd0;
    end else if (step) begin
      debounced_down <= debounced_down_next;
      change_pending <= change_pending_next;
      pending_since  <= pending_since_next;
      press_time     <= press_time_next;
      release_time   <= release_time_next;
      repeat_time    <= repeat_time_next;
      long_ticks     <= long_ticks_next;
      click_count    <= click_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/button_debounce_click_longpress.sv -----
// ----------------------------------------------------------------------------
// button_debounce_click_longpress
// Debounces an active-low button and reports press, release, long press
// and multi-click events, one result per poll
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  poll      in   pin_level, now_ms                         valid / ready
//  result    out  event_code, event_count, button_down      valid / ready
//  cfg_*     in   cfg_index, cfg_data                       cfg_we
//
//  One poll per cycle sustained while the result channel is not stalled; a
//  poll's result passes through the poll register, then the decision logic
//  in bdc_core into the result register.
//  rst is synchronous: clears the state and loads the default timings.
//  A stalled result holds the result register; the poll register still
//  takes a transaction while it is empty or the result register can drain.
`default_nettype none

module button_debounce_click_longpress
  import bdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  bdc_poll_if.sink         poll,
  bdc_event_if.source      result
);

  cfg_t        cfg;
  res_t        res;
  logic        s1_valid;
  logic        s1_pin;
  logic [31:0] s1_now;
  logic        adv;

  bdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // poll register moves on when the result register is free
  assign adv        = s1_valid && (!result.valid || result.ready);
  assign poll.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_pin <= poll.pin_level;
      s1_now <= poll.now_ms;
    end
  end

  bdc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (adv),
    .pin_level (s1_pin),
    .now_ms    (s1_now),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.event_code  <= res.event_code;
      result.event_count <= res.event_count;
      result.button_down <= res.button_down;
    end
  end

`ifndef SYNTHESIS
  // press, release and no-event results carry no count
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.event_code == EV_NONE || result.event_code == EV_PRESSED ||
                     result.event_code == EV_RELEASED) |-> result.event_count == 8'd0)
    else $error("count set on an event without one");

  // a press event leaves the button down, a release leaves it up
  a_edge_state: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.event_code == EV_PRESSED || result.event_code == EV_RELEASED)
    |-> result.button_down == (result.event_code == EV_PRESSED))
    else $error("press or release disagrees with debounced state");

  // long press only while held, with a tick count of at least one
  a_long: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_code == EV_LONG
    |-> result.button_down && result.event_count != 8'd0)
    else $error("bad long-press result");

  // click only while released, with a click count of at least one
  a_click: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_code == EV_CLICK
    |-> !result.button_down && result.event_count != 8'd0)
    else $error("bad click result");
`endif

endmodule

`default_nettype wire
